// File: hw/rtl/point_triangle_contact_core_assert.svh
// Assertion macros for the point/triangle contact core.
`ifndef POINT_TRIANGLE_CONTACT_CORE_ASSERT_SVH
`define POINT_TRIANGLE_CONTACT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define PTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTC_ASSERT(lbl, prop, msg)
`define PTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/ptc_pkg.sv
package ptc_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int MUL_STAGES_DEF  = 6;

  // degenerate threshold is 2^-EPS_LOG2 in real units
  localparam int EPS_LOG2 = 40;

  localparam int WEIGHT_W  = 17;
  localparam int NORMAL_W  = 18;
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } reg_idx_t;

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: hw/rtl/ptc_pipe.sv
module ptc_pipe #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  generate
    if (N == 0) begin : g_none
      assign dout = din;
    end else begin : g_sr
      logic [W-1:0] sr [0:N-1];
      always_ff @(posedge clk) begin
        if (en) begin
          sr[0] <= din;
          for (int i = 1; i < N; i++) begin
            sr[i] <= sr[i-1];
          end
        end
      end
      assign dout = sr[N-1];
    end
  endgenerate

endmodule

// File: hw/rtl/ptc_mul.sv
// Signed multiplier, one digit of b per stage, NST stages.
module ptc_mul #(
  parameter int WA  = 34,
  parameter int WB  = 34,
  parameter int NST = 6
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WA+WB-1:0] p
);

  localparam int DG = (WB + NST - 1) / NST;
  localparam int BW = DG * NST;
  localparam int PW = WA + WB;

  logic signed [WA-1:0] a_r [0:NST-1];
  logic        [BW-1:0] b_r [0:NST-1];
  logic signed [PW-1:0] acc [0:NST-1];

  logic signed [WA-1:0] a_s [0:NST-1];
  logic        [BW-1:0] b_s [0:NST-1];
  logic signed [PW-1:0] c_s [0:NST-1];
  logic signed [PW-1:0] pp  [0:NST-1];

  always_comb begin
    logic [DG-1:0] dig;
    logic signed [DG:0] dx;
    for (int j = 0; j < NST; j++) begin
      if (j == 0) begin
        a_s[j] = a;
        b_s[j] = BW'(b);
        c_s[j] = '0;
      end else begin
        a_s[j] = a_r[j-1];
        b_s[j] = b_r[j-1];
        c_s[j] = acc[j-1];
      end
      dig = b_s[j][j*DG +: DG];
      // top digit carries the sign
      dx = (j == NST - 1) ? $signed({dig[DG-1], dig}) : $signed({1'b0, dig});
      pp[j] = (PW'(a_s[j]) * PW'(dx)) <<< (j * DG);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NST; j++) begin
        a_r[j] <= a_s[j];
        b_r[j] <= b_s[j];
        acc[j] <= c_s[j] + pp[j];
      end
    end
  end

  assign p = acc[NST-1];

endmodule

// File: hw/rtl/ptc_root.sv
// Largest q < 2^BITS with q*div <= target (SQ=0) or q*q*div <= target (SQ=1).
// One quotient bit per stage; q*div and q*q*div are kept incrementally.
module ptc_root #(
  parameter int TW   = 64,
  parameter int DW   = 32,
  parameter int BITS = 18,
  parameter bit SQ   = 1'b0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [TW-1:0]   target,
  input  logic [DW-1:0]   div,
  output logic [BITS-1:0] q
);
  import ptc_pkg::*;

  localparam int W = imax(TW, DW + (SQ ? 2 * BITS : BITS)) + 2;

  logic [W-1:0]    tg_r  [0:BITS-1];
  logic [W-1:0]    dv_r  [0:BITS-1];
  logic [W-1:0]    acc_r [0:BITS-1];
  logic [W-1:0]    md_r  [0:BITS-1];
  logic [BITS-1:0] q_r   [0:BITS-1];

  logic [W-1:0]    tg_s  [0:BITS-1];
  logic [W-1:0]    dv_s  [0:BITS-1];
  logic [W-1:0]    acc_next [0:BITS-1];
  logic [W-1:0]    md_next  [0:BITS-1];
  logic [BITS-1:0] q_next   [0:BITS-1];

  always_comb begin
    logic [W-1:0] acc_s, md_s, cand, candm;
    logic [BITS-1:0] qs;
    int b;
    for (int i = 0; i < BITS; i++) begin
      b = BITS - 1 - i;
      if (i == 0) begin
        tg_s[i] = W'(target);
        dv_s[i] = W'(div);
        acc_s   = '0;
        md_s    = '0;
        qs      = '0;
      end else begin
        tg_s[i] = tg_r[i-1];
        dv_s[i] = dv_r[i-1];
        acc_s   = acc_r[i-1];
        md_s    = md_r[i-1];
        qs      = q_r[i-1];
      end
      // (q + 2^b)*d and (q + 2^b)^2*d
      candm = md_s + (dv_s[i] << b);
      cand  = SQ ? (acc_s + (md_s << (b + 1)) + (dv_s[i] << (2 * b))) : candm;
      if (cand <= tg_s[i]) begin
        acc_next[i] = cand;
        md_next[i]  = candm;
        q_next[i]   = qs | (BITS'(1) << b);
      end else begin
        acc_next[i] = acc_s;
        md_next[i]  = md_s;
        q_next[i]   = qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < BITS; i++) begin
        tg_r[i]  <= tg_s[i];
        dv_r[i]  <= dv_s[i];
        acc_r[i] <= acc_next[i];
        md_r[i]  <= md_next[i];
        q_r[i]   <= q_next[i];
      end
    end
  end

  assign q = q_r[BITS-1];

endmodule

// File: hw/rtl/point_triangle_contact_core.sv
// Point/triangle contact core: each input beat carries a body position and the
// three vertices a, b, c of a triangle (signed Q16.16). The contact point is the
// body position plus the offset registers; the core projects it onto the
// triangle and returns hit_valid (tuser) with the barycentric weights, the unit
// normal along (b-a)x(c-a) and the signed depth along it; a degenerate triangle
// or a point outside gives hit_valid 0 and all-zero data. All arithmetic is
// exact integer, so results are bit-exact. One beat is accepted every cycle
// while the input is not stalled; latency is set by the three multiplier chains
// and the depth square-root search, which resolves one result bit per stage. An
// output register plus a skid register decouple the master side; the input
// stalls only when both are full. Offsets (cfg_we/cfg_addr/cfg_wdata) must be
// written only while the core idles; the core itself does not enforce this.
`include "point_triangle_contact_core_assert.svh"

module point_triangle_contact_core #(
  parameter int FRAC_BITS   = ptc_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF,
  parameter int MUL_STAGES  = ptc_pkg::MUL_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [ptc_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  // input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // body_x, body_y, body_z, vertex_a_x/y/z, vertex_b_x/y/z, vertex_c_x/y/z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // weight_a, weight_b, weight_c, normal_x, normal_y, normal_z, depth
  output logic [((3*ptc_pkg::WEIGHT_W+3*ptc_pkg::NORMAL_W+COORD_WIDTH+7)/8)*8-1:0]
               m_axis_tdata,
  // hit_valid
  output logic m_axis_tuser
);
  import ptc_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int NST   = MUL_STAGES;
  localparam int OUT_W = ((3*WEIGHT_W + 3*NORMAL_W + CW + 7) / 8) * 8;

  localparam int QW  = CW + 2;       // edges and point offset
  localparam int PW1 = 2 * QW;       // coordinate products
  localparam int DW  = PW1 + 2;      // dot products
  localparam int KW  = PW1 + 1;      // cross product
  localparam int GW  = 2 * DW + 1;   // Gram determinant and numerators
  localparam int TW  = KW + QW + 2;  // q . k
  localparam int AW  = TW + 1;       // |q . k|
  localparam int SQW = 2 * AW;
  localparam int KKW = 2 * KW;
  localparam int WBITS = FB + 2;
  localparam int LS    = imax(WBITS, CW);
  localparam int LAT   = 3 * NST + 4 + LS;
  localparam int EPSX  = (4 * FB > EPS_LOG2) ? 4 * FB - EPS_LOG2 : 0;

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] off [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      off[0] <= '0;
      off[1] <= '0;
      off[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OFFSET_X: off[0] <= cfg_wdata;
        REG_OFFSET_Y: off[1] <= cfg_wdata;
        REG_OFFSET_Z: off[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic out_v, skid_v;
  logic [LAT-1:0] vld;

  assign en = !skid_v;  // pipeline holds only while the skid is full
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 0: edges
  logic signed [CW-1:0] fld [0:11];
  logic signed [QW-1:0] e0 [0:2];
  logic signed [QW-1:0] e1 [0:2];
  logic signed [QW-1:0] qv [0:2];

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      fld[i] = s_axis_tdata[i*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0[i] <= QW'(fld[6+i]) - QW'(fld[3+i]);
        e1[i] <= QW'(fld[9+i]) - QW'(fld[3+i]);
        qv[i] <= QW'(fld[i]) + QW'(off[i]) - QW'(fld[3+i]);
      end
    end
  end

  // ---------------------------------------------------------------- M1: coordinate products
  // 0..14: d00, d01, d11, d20, d21 terms; 15..20: cross product terms
  logic signed [QW-1:0]  m1a [0:20];
  logic signed [QW-1:0]  m1b [0:20];
  logic signed [PW1-1:0] m1p [0:20];

  always_comb begin
    for (int g = 0; g < 5; g++) begin
      for (int i = 0; i < 3; i++) begin
        m1a[3*g+i] = (g < 2) ? e0[i] : ((g == 2) ? e1[i] : qv[i]);
        m1b[3*g+i] = (g == 0 || g == 3) ? e0[i] : e1[i];
      end
    end
    m1a[15] = e0[1]; m1b[15] = e1[2];
    m1a[16] = e0[2]; m1b[16] = e1[1];
    m1a[17] = e0[2]; m1b[17] = e1[0];
    m1a[18] = e0[0]; m1b[18] = e1[2];
    m1a[19] = e0[0]; m1b[19] = e1[1];
    m1a[20] = e0[1]; m1b[20] = e1[0];
  end

  generate
    for (genvar n = 0; n < 21; n++) begin : g_m1
      ptc_mul #(.WA(QW), .WB(QW), .NST(NST)) u_mul (
        .clk (clk), .en (en), .a (m1a[n]), .b (m1b[n]), .p (m1p[n])
      );
    end
  endgenerate

  logic [3*QW-1:0] q_a_vec;
  ptc_pipe #(.W(3*QW), .N(NST+1)) u_q_dly (
    .clk (clk), .en (en), .din ({qv[2], qv[1], qv[0]}), .dout (q_a_vec)
  );

  // ---------------------------------------------------------------- stage A: sums
  logic signed [DW-1:0] dd [0:4];
  logic signed [KW-1:0] kv [0:2];
  logic signed [QW-1:0] q_a [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 5; g++) begin
        dd[g] <= DW'(m1p[3*g]) + DW'(m1p[3*g+1]) + DW'(m1p[3*g+2]);
      end
      for (int i = 0; i < 3; i++) begin
        kv[i] <= KW'(m1p[15+2*i]) - KW'(m1p[16+2*i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_a[i] = q_a_vec[i*QW +: QW];
    end
  end

  // ---------------------------------------------------------------- M2: Gram terms
  logic signed [DW-1:0]    m2a [0:5];
  logic signed [DW-1:0]    m2b [0:5];
  logic signed [2*DW-1:0]  m2p [0:5];
  logic signed [KW+QW-1:0] m2t [0:2];
  logic signed [KKW-1:0]   m2k [0:2];

  // dd index: 0 d00, 1 d01, 2 d11, 3 d20, 4 d21
  always_comb begin
    m2a[0] = dd[0]; m2b[0] = dd[2];
    m2a[1] = dd[1]; m2b[1] = dd[1];
    m2a[2] = dd[2]; m2b[2] = dd[3];
    m2a[3] = dd[1]; m2b[3] = dd[4];
    m2a[4] = dd[0]; m2b[4] = dd[4];
    m2a[5] = dd[1]; m2b[5] = dd[3];
  end

  generate
    for (genvar n = 0; n < 6; n++) begin : g_m2d
      ptc_mul #(.WA(DW), .WB(DW), .NST(NST)) u_mul (
        .clk (clk), .en (en), .a (m2a[n]), .b (m2b[n]), .p (m2p[n])
      );
    end
    for (genvar n = 0; n < 3; n++) begin : g_m2k
      ptc_mul #(.WA(KW), .WB(QW), .NST(NST)) u_mul_t (
        .clk (clk), .en (en), .a (kv[n]), .b (q_a[n]), .p (m2t[n])
      );
      ptc_mul #(.WA(KW), .WB(KW), .NST(NST)) u_mul_k (
        .clk (clk), .en (en), .a (kv[n]), .b (kv[n]), .p (m2k[n])
      );
    end
  endgenerate

  logic [2:0] ks_f;
  ptc_pipe #(.W(3), .N(2*NST+2+LS)) u_ks_dly (
    .clk (clk), .en (en), .din ({kv[2][KW-1], kv[1][KW-1], kv[0][KW-1]}), .dout (ks_f)
  );

  // ---------------------------------------------------------------- stage B
  logic signed [GW-1:0]  den_b, nb_b, nc_b;
  logic signed [TW-1:0]  t_b;
  logic        [KKW-1:0] kk_b [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      den_b <= GW'(m2p[0]) - GW'(m2p[1]);
      nb_b  <= GW'(m2p[2]) - GW'(m2p[3]);
      nc_b  <= GW'(m2p[4]) - GW'(m2p[5]);
      t_b   <= TW'(m2t[0]) + TW'(m2t[1]) + TW'(m2t[2]);
      for (int i = 0; i < 3; i++) begin
        kk_b[i] <= m2k[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage C: tests
  logic signed [GW:0]    nsum;
  logic                  hit_c, ts_c;
  logic signed [AW-1:0]  tabs_c;
  logic        [GW-1:0]  den_c, nb_c, nc_c;
  logic        [KKW-1:0] kk_c [0:2];

  assign nsum = {nb_b[GW-1], nb_b} + {nc_b[GW-1], nc_b};

  always_ff @(posedge clk) begin
    if (en) begin
      // non-degenerate, and inside on the numerators (zero weights count as inside)
      hit_c  <= !den_b[GW-1] && ($unsigned(den_b) >= (GW'(1) << EPSX)) &&
                !nb_b[GW-1] && !nc_b[GW-1] && (nsum <= $signed({den_b[GW-1], den_b}));
      ts_c   <= t_b[TW-1];
      tabs_c <= t_b[TW-1] ? -AW'(t_b) : AW'(t_b);
      den_c  <= den_b;
      nb_c   <= nb_b;
      nc_c   <= nc_b;
      for (int i = 0; i < 3; i++) begin
        kk_c[i] <= kk_b[i];
      end
    end
  end

  // ---------------------------------------------------------------- M3: depth square
  logic signed [SQW-1:0] tsq;

  ptc_mul #(.WA(AW), .WB(AW), .NST(NST)) u_mul_tsq (
    .clk (clk), .en (en), .a (tabs_c), .b (tabs_c), .p (tsq)
  );

  logic [3*KKW+3*GW-1:0] srch_vec;
  logic [GW-1:0]  den_s, nb_s, nc_s;
  logic [KKW-1:0] kk_s [0:2];
  logic           hit_f, ts_f;

  ptc_pipe #(.W(3*KKW+3*GW), .N(NST)) u_srch_dly (
    .clk  (clk), .en (en),
    .din  ({kk_c[2], kk_c[1], kk_c[0], nc_c, nb_c, den_c}),
    .dout (srch_vec)
  );

  ptc_pipe #(.W(2), .N(NST+LS)) u_flag_dly (
    .clk (clk), .en (en), .din ({hit_c, ts_c}), .dout ({hit_f, ts_f})
  );

  always_comb begin
    den_s = srch_vec[0 +: GW];
    nb_s  = srch_vec[GW +: GW];
    nc_s  = srch_vec[2*GW +: GW];
    for (int i = 0; i < 3; i++) begin
      kk_s[i] = srch_vec[3*GW + i*KKW +: KKW];
    end
  end

  // ---------------------------------------------------------------- searches
  logic [WBITS-1:0] wb_r, wc_r, wb_f, wc_f;
  logic [WBITS-1:0] nm_r [0:2];
  logic [WBITS-1:0] nm_f [0:2];
  logic [CW-1:0]    dm_r, dm_f;

  ptc_root #(.TW(GW+FB), .DW(GW), .BITS(WBITS), .SQ(1'b0)) u_div_b (
    .clk (clk), .en (en), .target ({nb_s, {FB{1'b0}}}), .div (den_s), .q (wb_r)
  );
  ptc_root #(.TW(GW+FB), .DW(GW), .BITS(WBITS), .SQ(1'b0)) u_div_c (
    .clk (clk), .en (en), .target ({nc_s, {FB{1'b0}}}), .div (den_s), .q (wc_r)
  );
  ptc_pipe #(.W(2*WBITS), .N(LS-WBITS)) u_w_dly (
    .clk (clk), .en (en), .din ({wc_r, wb_r}), .dout ({wc_f, wb_f})
  );

  generate
    for (genvar n = 0; n < 3; n++) begin : g_nrm
      ptc_root #(.TW(KKW+2*FB), .DW(GW), .BITS(WBITS), .SQ(1'b1)) u_root (
        .clk (clk), .en (en), .target ({kk_s[n], {(2*FB){1'b0}}}), .div (den_s),
        .q (nm_r[n])
      );
      ptc_pipe #(.W(WBITS), .N(LS-WBITS)) u_dly (
        .clk (clk), .en (en), .din (nm_r[n]), .dout (nm_f[n])
      );
    end
  endgenerate

  ptc_root #(.TW(SQW), .DW(GW), .BITS(CW), .SQ(1'b1)) u_root_depth (
    .clk (clk), .en (en), .target ($unsigned(tsq)), .div (den_s), .q (dm_r)
  );
  ptc_pipe #(.W(CW), .N(LS-CW)) u_d_dly (
    .clk (clk), .en (en), .din (dm_r), .dout (dm_f)
  );

  // ---------------------------------------------------------------- result assembly
  logic [WBITS-1:0]      wa_f;
  logic signed [WBITS:0] nsg [0:2];
  logic [CW-1:0]         lim, dsat, dep;
  logic [OUT_W-1:0]      res_pay;

  always_comb begin
    wa_f = (WBITS'(1) << FB) - wb_f - wc_f;  // weights sum to exactly one
    for (int i = 0; i < 3; i++) begin
      nsg[i] = ks_f[i] ? -$signed({1'b0, nm_f[i]}) : $signed({1'b0, nm_f[i]});
    end
    lim = CW'(1) << (CW - 1);
    if (ts_f) begin
      dsat = (dm_f > lim) ? lim : dm_f;
      dep  = '0 - dsat;
    end else begin
      dsat = (dm_f > lim - 1'b1) ? lim - 1'b1 : dm_f;
      dep  = dsat;
    end
    if (hit_f) begin
      res_pay = OUT_W'({dep,
                        NORMAL_W'(nsg[2]), NORMAL_W'(nsg[1]), NORMAL_W'(nsg[0]),
                        WEIGHT_W'(wc_f), WEIGHT_W'(wb_f), WEIGHT_W'(wa_f)});
    end else begin
      res_pay = '0;
    end
  end

  // ---------------------------------------------------------------- output + skid
  logic             out_hit, skid_hit;
  logic [OUT_W-1:0] out_pay, skid_pay;
  logic             res_v;

  assign res_v = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_axis_tready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= res_v;
      end
    end else if (res_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_axis_tready) begin
      if (skid_v) begin
        out_hit <= skid_hit;
        out_pay <= skid_pay;
      end else begin
        out_hit <= hit_f;
        out_pay <= res_pay;
      end
    end else if (res_v && en) begin
      skid_hit <= hit_f;
      skid_pay <= res_pay;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_pay;
  assign m_axis_tuser  = out_hit;

  // ---------------------------------------------------------------- checks
  `PTC_ASSERT(a_skid_needs_out, skid_v |-> out_v, "skid full with output empty")
  `PTC_ASSERT(a_skid_fill, $rose(skid_v) |-> $past(out_v && !m_axis_tready), "skid filled without stall")
  `PTC_ASSERT(a_miss_zero, (out_v && !out_hit) |-> (out_pay == '0), "miss beat carries data")
  `PTC_ASSERT(a_weight_sum, (out_v && out_hit) |-> (WEIGHT_W'(out_pay[0 +: WEIGHT_W] + out_pay[WEIGHT_W +: WEIGHT_W] + out_pay[2*WEIGHT_W +: WEIGHT_W]) == WEIGHT_W'(64'(1) << FB)), "weights do not sum to one")
  `PTC_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_v && !skid_v), "output not empty after reset")

endmodule
